// ----- rtl/rna_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the rational number alu
// used by rna_ctrl, rna_dp and the top level; no dependencies

package rna_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 32;
    localparam int FIELD_W = 32;
    localparam int DATA_W = 64;
    localparam int DEN_W = 63;
    localparam int SHIFT_W = 6;
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 6;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 136;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_NEG = 4'd4;
    localparam logic [3:0] OP_INC = 4'd5;
    localparam logic [3:0] OP_DEC = 4'd6;
    localparam logic [3:0] OP_CMP = 4'd7;
    localparam logic [3:0] OP_RED = 4'd8;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] MUL_X = 2'd0;
    localparam logic [1:0] MUL_Y = 2'd1;
    localparam logic [1:0] MUL_D = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum;
        logic       gcd_halve_both;
        logic       gcd_halve_a;
        logic       gcd_step;
        logic       g_from_a;
        logic       g_from_b;
        logic       div_step;
        logic       commit;
    } rna_cmd_t;

    typedef struct packed {
        logic early_exit;
        logic is_cmp;
        logic ga_zero;
        logic both_even;
        logic ga_even;
        logic gb_zero;
    } rna_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rna_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// controller state machine of the rational number alu
// depends on rna_pkg for the command and status structs

module rna_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire rna_pkg::rna_stat_t stat,
    output rna_pkg::rna_cmd_t       cmd
);
    import rna_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL_X    = 4'd1;
    localparam logic [3:0] S_MUL_Y    = 4'd2;
    localparam logic [3:0] S_MUL_D    = 4'd3;
    localparam logic [3:0] S_SUM      = 4'd4;
    localparam logic [3:0] S_GCD_TWO  = 4'd5;
    localparam logic [3:0] S_GCD_ODD  = 4'd6;
    localparam logic [3:0] S_GCD_LOOP = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_COMMIT   = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 valid_reg, valid_next;
    logic                 out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X: begin
                if (stat.early_exit) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_X;
                    state_next  = S_MUL_Y;
                end
            end
            S_MUL_Y: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Y;
                state_next  = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = stat.is_cmp ? S_COMMIT : S_GCD_TWO;
            end
            S_GCD_TWO: begin
                priority if (stat.ga_zero) begin
                    cmd.g_from_b = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end else if (stat.both_even) begin
                    cmd.gcd_halve_both = 1'b1;
                end else begin
                    state_next = S_GCD_ODD;
                end
            end
            S_GCD_ODD: begin
                if (stat.ga_even) begin
                    cmd.gcd_halve_a = 1'b1;
                end else begin
                    state_next = S_GCD_LOOP;
                end
            end
            S_GCD_LOOP: begin
                if (stat.gb_zero) begin
                    cmd.g_from_a = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rna_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// datapath of the rational number alu: multiplier, adder, binary gcd, dividers
// depends on rna_pkg; driven by rna_ctrl through rna_cmd_t

module rna_dp #(
    parameter int OPERAND_WIDTH = rna_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                        aclk,
    input  wire rna_pkg::rna_cmd_t           cmd,
    output rna_pkg::rna_stat_t               stat,
    input  wire logic [3:0]                  in_op,
    input  wire logic [rna_pkg::FIELD_W-1:0] in_a_num,
    input  wire logic [rna_pkg::FIELD_W-1:0] in_a_den,
    input  wire logic [rna_pkg::FIELD_W-1:0] in_b_num,
    input  wire logic [rna_pkg::FIELD_W-1:0] in_b_den,
    output logic [rna_pkg::DATA_W-1:0]       res_num,
    output logic [rna_pkg::DEN_W-1:0]        res_den,
    output logic                             is_less,
    output logic                             is_greater,
    output logic                             is_equal,
    output logic [1:0]                       status
);
    import rna_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [3:0]        op_reg;
    logic              an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [W-1:0]      an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic              x_neg_reg, y_neg_reg, d_neg_reg, n_neg_reg;
    logic [DATA_W-1:0] x_mag_reg, y_mag_reg, d_mag_reg, n_mag_reg;
    logic [DATA_W-1:0] ga_reg, gb_reg, g_reg;
    logic [SHIFT_W-1:0] k_reg;
    logic [DATA_W-1:0] qn_reg, qd_reg, remn_reg, remd_reg;
    logic [DATA_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              lt_reg, gt_reg, eq_reg;
    logic              lt_next, gt_next, eq_next;
    logic [1:0]        st_reg, st_next;

    // sign-magnitude of the low operand bits
    function automatic logic [W:0] to_sm(input logic [FIELD_W-1:0] v);
        logic [W-1:0] low;
        low = v[W-1:0];
        return {low[W-1], low[W-1] ? (W'(0) - low) : low};
    endfunction

    logic [W:0] an_sm, ad_sm, bn_sm, bd_sm;
    assign an_sm = to_sm(in_a_num);
    assign ad_sm = to_sm(in_a_den);
    assign bn_sm = to_sm(in_b_num);
    assign bd_sm = to_sm(in_b_den);

    logic binary_op, bad_op, zero_den;
    assign bad_op    = (op_reg > OP_RED);
    assign binary_op = (op_reg == OP_ADD) || (op_reg == OP_SUB) || (op_reg == OP_MUL)
                    || (op_reg == OP_DIV) || (op_reg == OP_CMP);
    assign zero_den  = (ad_mag_reg == '0) || (binary_op && bd_mag_reg == '0)
                    || (op_reg == OP_DIV && bn_mag_reg == '0);

    // multiplier operand selection
    logic         ma_neg, mb_neg;
    logic [W-1:0] ma_mag, mb_mag;
    logic [2*W-1:0] prod;
    logic         prod_neg;

    always_comb begin
        ma_neg = an_neg_reg;
        ma_mag = an_mag_reg;
        mb_neg = 1'b0;
        mb_mag = W'(1);
        unique case (cmd.mul_sel)
            MUL_X: begin
                ma_neg = an_neg_reg;
                ma_mag = an_mag_reg;
                if (op_reg == OP_MUL) begin
                    mb_neg = bn_neg_reg;
                    mb_mag = bn_mag_reg;
                end else if (binary_op) begin
                    mb_neg = bd_neg_reg;
                    mb_mag = bd_mag_reg;
                end
            end
            MUL_Y: begin
                priority if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_CMP) begin
                    ma_neg = bn_neg_reg;
                    ma_mag = bn_mag_reg;
                    mb_neg = ad_neg_reg;
                    mb_mag = ad_mag_reg;
                end else if (op_reg == OP_INC || op_reg == OP_DEC) begin
                    ma_neg = ad_neg_reg;
                    ma_mag = ad_mag_reg;
                end else begin
                    ma_neg = 1'b0;
                    ma_mag = '0;
                end
            end
            MUL_D: begin
                ma_neg = ad_neg_reg;
                ma_mag = ad_mag_reg;
                if (op_reg == OP_DIV) begin
                    mb_neg = bn_neg_reg;
                    mb_mag = bn_mag_reg;
                end else if (binary_op) begin
                    mb_neg = bd_neg_reg;
                    mb_mag = bd_mag_reg;
                end
            end
            default: begin
                ma_mag = '0;
            end
        endcase
    end

    assign prod     = ma_mag * mb_mag;
    assign prod_neg = (prod != '0) && (ma_neg != mb_neg);

    // signed add or subtract of the x and y products
    logic              sub_op, xneg_eff, yneg_eff, sum_neg;
    logic [DATA_W-1:0] sum_mag;

    assign sub_op   = (op_reg == OP_SUB) || (op_reg == OP_DEC) || (op_reg == OP_CMP);
    assign xneg_eff = (op_reg == OP_NEG) ? ((x_mag_reg != '0) && !x_neg_reg) : x_neg_reg;
    assign yneg_eff = sub_op ^ y_neg_reg;

    always_comb begin
        priority if (xneg_eff == yneg_eff) begin
            sum_neg = xneg_eff;
            sum_mag = x_mag_reg + y_mag_reg;
        end else if (x_mag_reg >= y_mag_reg) begin
            sum_neg = xneg_eff;
            sum_mag = x_mag_reg - y_mag_reg;
        end else begin
            sum_neg = yneg_eff;
            sum_mag = y_mag_reg - x_mag_reg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    // one restoring division step for each of numerator and denominator
    logic [DATA_W:0] remn_sh, remd_sh;
    logic            n_ge, d_ge;
    assign remn_sh = {remn_reg, qn_reg[DATA_W-1]};
    assign remd_sh = {remd_reg, qd_reg[DATA_W-1]};
    assign n_ge    = remn_sh >= {1'b0, g_reg};
    assign d_ge    = remd_sh >= {1'b0, g_reg};

    assign stat.early_exit = bad_op || zero_den;
    assign stat.is_cmp     = (op_reg == OP_CMP);
    assign stat.ga_zero    = (ga_reg == '0);
    assign stat.both_even  = !ga_reg[0] && !gb_reg[0];
    assign stat.ga_even    = !ga_reg[0];
    assign stat.gb_zero    = (gb_reg == '0);

    logic frac_neg;
    assign frac_neg = (qn_reg != '0) && (n_neg_reg != d_neg_reg);

    // result fields for the commit
    always_comb begin
        num_next = '0;
        den_next = DEN_W'(1);
        lt_next  = 1'b0;
        gt_next  = 1'b0;
        eq_next  = 1'b0;
        st_next  = ST_OK;
        priority if (bad_op) begin
            st_next = ST_OK;
        end else if (zero_den) begin
            st_next = ST_ZERO_DEN;
        end else if (op_reg == OP_CMP) begin
            priority if (n_mag_reg == '0) begin
                eq_next = 1'b1;
            end else if (n_neg_reg != d_neg_reg) begin
                lt_next = 1'b1;
            end else begin
                gt_next = 1'b1;
            end
        end else if (qn_reg[DATA_W-1]) begin
            st_next = ST_OVERFLOW;
        end else begin
            num_next = frac_neg ? (DATA_W'(0) - qn_reg) : qn_reg;
            den_next = qd_reg[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_op;
            an_neg_reg <= an_sm[W];
            an_mag_reg <= an_sm[W-1:0];
            ad_neg_reg <= ad_sm[W];
            ad_mag_reg <= ad_sm[W-1:0];
            bn_neg_reg <= bn_sm[W];
            bn_mag_reg <= bn_sm[W-1:0];
            bd_neg_reg <= bd_sm[W];
            bd_mag_reg <= bd_sm[W-1:0];
        end
        if (cmd.mul_en) begin
            unique case (cmd.mul_sel)
                MUL_X: begin
                    x_neg_reg <= prod_neg;
                    x_mag_reg <= DATA_W'(prod);
                end
                MUL_Y: begin
                    y_neg_reg <= prod_neg;
                    y_mag_reg <= DATA_W'(prod);
                end
                default: begin
                    d_neg_reg <= ma_neg != mb_neg;
                    d_mag_reg <= DATA_W'(prod);
                end
            endcase
        end
        if (cmd.sum) begin
            n_neg_reg <= sum_neg;
            n_mag_reg <= sum_mag;
            ga_reg    <= sum_mag;
            gb_reg    <= d_mag_reg;
            k_reg     <= '0;
        end
        if (cmd.gcd_halve_both) begin
            ga_reg <= ga_reg >> 1;
            gb_reg <= gb_reg >> 1;
            k_reg  <= k_reg + 1'b1;
        end
        if (cmd.gcd_halve_a) begin
            ga_reg <= ga_reg >> 1;
        end
        if (cmd.gcd_step) begin
            priority if (!gb_reg[0]) begin
                gb_reg <= gb_reg >> 1;
            end else if (ga_reg > gb_reg) begin
                ga_reg <= gb_reg;
                gb_reg <= ga_reg - gb_reg;
            end else begin
                gb_reg <= gb_reg - ga_reg;
            end
        end
        if (cmd.g_from_a || cmd.g_from_b) begin
            g_reg    <= cmd.g_from_b ? gb_reg : (ga_reg << k_reg);
            qn_reg   <= n_mag_reg;
            qd_reg   <= d_mag_reg;
            remn_reg <= '0;
            remd_reg <= '0;
        end
        if (cmd.div_step) begin
            remn_reg <= n_ge ? DATA_W'(remn_sh - {1'b0, g_reg}) : DATA_W'(remn_sh);
            remd_reg <= d_ge ? DATA_W'(remd_sh - {1'b0, g_reg}) : DATA_W'(remd_sh);
            qn_reg   <= {qn_reg[DATA_W-2:0], n_ge};
            qd_reg   <= {qd_reg[DATA_W-2:0], d_ge};
        end
        if (cmd.commit) begin
            num_reg <= num_next;
            den_reg <= den_next;
            lt_reg  <= lt_next;
            gt_reg  <= gt_next;
            eq_reg  <= eq_next;
            st_reg  <= st_next;
        end
    end

    assign res_num    = num_reg;
    assign res_den    = den_reg;
    assign is_less    = lt_reg;
    assign is_greater = gt_reg;
    assign is_equal   = eq_reg;
    assign status     = st_reg;

endmodule

`default_nettype wire

// ----- rtl/rational_number_alu_core.sv -----
`timescale 1ns / 1ps
// rational number alu: one item at a time; 3 multiplier steps (x, y, d), the sum,
// binary gcd steps, 64 divide steps, then a commit that waits for a free output;
// compare items skip gcd and divide, zero-denominator and unused-opcode items skip
// to the commit; the gcd loop and the bit-serial dividers set the rate
// aresetn (synchronous, active low) clears the controller and the output valid
// depends on rna_pkg, rna_ctrl, rna_dp
`default_nettype none

module rational_number_alu_core #(
    parameter int OPERAND_WIDTH = rna_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // op[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100], zero pad
    input  wire logic [rna_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // res_num[63:0], res_den[126:64], is_less[127], is_greater[128],
    // is_equal[129], status[131:130], zero pad
    output logic [rna_pkg::M_TDATA_W-1:0]      m_tdata
);
    import rna_pkg::*;

    rna_cmd_t  cmd;
    rna_stat_t stat;

    logic [DATA_W-1:0] res_num;
    logic [DEN_W-1:0]  res_den;
    logic              is_less, is_greater, is_equal;
    logic [1:0]        status;

    // controller owns the handshakes and sequencing
    rna_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath captures the transfer when cmd.load is set
    rna_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[3:0]),
        .in_a_num   (s_tdata[35:4]),
        .in_a_den   (s_tdata[67:36]),
        .in_b_num   (s_tdata[99:68]),
        .in_b_den   (s_tdata[131:100]),
        .res_num    (res_num),
        .res_den    (res_den),
        .is_less    (is_less),
        .is_greater (is_greater),
        .is_equal   (is_equal),
        .status     (status)
    );

    // output register lives in the datapath; pack it for the result transfer
    assign m_tdata = {4'b0000, status, is_equal, is_greater, is_less, res_den, res_num};

endmodule

`default_nettype wire

// ----- rtl/rna_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// port-level checker for rational_number_alu_core, attached by bind
// depends only on the top-level ports

module rna_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[126:64] != 63'd0)
        else $error("zero result denominator");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[131:130] != 2'd0 |->
            m_tdata[63:0] == 64'd0 && m_tdata[126:64] == 63'd1 && m_tdata[129:127] == 3'd0)
        else $error("error result not cleared");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[129:127]))
        else $error("more than one compare flag");

endmodule

bind rational_number_alu_core rna_checker u_rna_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/rational_number_alu_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for rational_number_alu_core: directed and random
// fraction operations, predicted in-bench and compared field by field
// depends on rna_pkg and the rtl of rational_number_alu_core

module rational_number_alu_core_tb;
    import rna_pkg::*;

    localparam int OPW = DEFAULT_OPERAND_WIDTH;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_equal;
        logic        is_greater;
        logic        is_less;
        logic [62:0] res_den;
        logic [63:0] res_num;
    } frac_res_t;

    // sign-magnitude value with a 64-bit magnitude
    typedef struct {
        bit          neg;
        bit [63:0]   mag;
    } sm_t;

    // ---------------------------------------------------------------
    // result tracker: predicts each accepted transfer, checks outputs
    // ---------------------------------------------------------------
    class frac_scoreboard;
        frac_res_t pending[$];
        int        errors;

        function automatic longint sext(logic [31:0] v);
            bit [63:0] m;
            m = 64'(v) & ((64'd1 << OPW) - 1);
            if (m[OPW-1]) m = m - (64'd1 << OPW);
            return longint'(m);
        endfunction

        function automatic bit [63:0] mag_of(longint x);
            return x < 0 ? 64'd0 - 64'(x) : 64'(x);
        endfunction

        function automatic sm_t smv(longint x);
            sm_t r;
            r.neg = x < 0;
            r.mag = mag_of(x);
            return r;
        endfunction

        function automatic sm_t product(longint x, longint y);
            sm_t r;
            r.mag = mag_of(x) * mag_of(y);
            r.neg = (r.mag != 0) && ((x < 0) != (y < 0));
            return r;
        endfunction

        function automatic sm_t sum(sm_t x, sm_t y, bit sub);
            sm_t r;
            bit yn;
            yn = sub ? !y.neg : y.neg;
            if (x.neg == yn) begin
                r.neg = x.neg;
                r.mag = x.mag + y.mag;
            end else if (x.mag >= y.mag) begin
                r.neg = x.neg;
                r.mag = x.mag - y.mag;
            end else begin
                r.neg = yn;
                r.mag = y.mag - x.mag;
            end
            if (r.mag == 0) r.neg = 0;
            return r;
        endfunction

        function automatic bit [63:0] gcd(bit [63:0] a, bit [63:0] b);
            bit [63:0] t;
            if (a == 0) return b;
            if (b == 0) return a;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function automatic frac_res_t plain(logic [1:0] st);
            frac_res_t r;
            r = '0;
            r.res_den = 63'd1;
            r.status = st;
            return r;
        endfunction

        function automatic frac_res_t predict(logic [3:0] op, logic [31:0] an_r,
                                              logic [31:0] ad_r, logic [31:0] bn_r,
                                              logic [31:0] bd_r);
            longint an, ad, bn, bd;
            sm_t n, d, diff;
            bit [63:0] g, nm, dm;
            bit binary;
            frac_res_t r;
            an = sext(an_r);
            ad = sext(ad_r);
            bn = sext(bn_r);
            bd = sext(bd_r);
            binary = (op <= OP_DIV) || (op == OP_CMP);
            if (op > OP_RED) return plain(ST_OK);
            if (ad == 0 || (binary && bd == 0) || (op == OP_DIV && bn == 0))
                return plain(ST_ZERO_DEN);
            case (op)
                OP_ADD, OP_SUB: begin
                    n = sum(product(an, bd), product(bn, ad), op == OP_SUB);
                    d = product(ad, bd);
                end
                OP_MUL: begin
                    n = product(an, bn);
                    d = product(ad, bd);
                end
                OP_DIV: begin
                    n = product(an, bd);
                    d = product(ad, bn);
                end
                OP_NEG: begin
                    n = smv(an);
                    n.neg = (n.mag != 0) && !n.neg;
                    d = smv(ad);
                end
                OP_INC, OP_DEC: begin
                    n = sum(smv(an), smv(ad), op == OP_DEC);
                    d = smv(ad);
                end
                OP_CMP: begin
                    diff = sum(product(an, bd), product(bn, ad), 1'b1);
                    r = plain(ST_OK);
                    // sign of a-b is the sign of the cross difference times sign of ad*bd
                    if (diff.mag == 0) r.is_equal = 1;
                    else if (diff.neg != ((ad < 0) != (bd < 0))) r.is_less = 1;
                    else r.is_greater = 1;
                    return r;
                end
                default: begin
                    n = smv(an);
                    d = smv(ad);
                end
            endcase
            g = gcd(n.mag, d.mag);
            nm = n.mag / g;
            dm = d.mag / g;
            if (nm > 64'h7FFF_FFFF_FFFF_FFFF) return plain(ST_OVERFLOW);
            r = plain(ST_OK);
            r.res_num = ((nm != 0) && (n.neg != d.neg)) ? 64'd0 - nm : nm;
            r.res_den = dm[62:0];
            return r;
        endfunction

        function void note_input(logic [S_TDATA_W-1:0] d);
            pending.push_back(predict(d[3:0], d[35:4], d[67:36], d[99:68], d[131:100]));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            frac_res_t got, want;
            got = d[131:0];
            if (pending.size() == 0) begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.res_num !== want.res_num) begin
                $display("%0t res_num: expected %0d actual %0d", $time,
                         $signed(want.res_num), $signed(got.res_num));
                errors++;
            end
            if (got.res_den !== want.res_den) begin
                $display("%0t res_den: expected %0d actual %0d", $time,
                         want.res_den, got.res_den);
                errors++;
            end
            if (got.is_less !== want.is_less || got.is_greater !== want.is_greater ||
                got.is_equal !== want.is_equal) begin
                $display("%0t flags lt/gt/eq: expected %b%b%b actual %b%b%b", $time,
                         want.is_less, want.is_greater, want.is_equal,
                         got.is_less, got.is_greater, got.is_equal);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t status: expected %0d actual %0d", $time,
                         want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_TDATA_W-1:0]  m_tdata;

    frac_scoreboard sb = new();
    int send_idle_pct = 35;
    int recv_idle_pct = 61;
    int quiet_cycles = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    rational_number_alu_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // receiver side: random stall, check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one input transfer, with a random leading gap; tvalid stays up after
    // the transfer until the next gap or the next item replaces it
    task automatic send_item(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'd0, bd, bn, ad, an, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(s_tdata);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(16) - 8;
            1: return $urandom_range(2000) - 1000;
            2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(255);
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        logic [3:0] op;
        logic [31:0] bn, bd;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            bd = rand_operand();
            bn = rand_operand();
            // mostly nonzero denominators so the arithmetic path is reached
            if ($urandom_range(15) == 0) bd = 0;
            else if (bd == 0) bd = 1;
            send_item(op, rand_operand(),
                      ($urandom_range(15) == 0) ? 32'd0 : (rand_operand() | 32'd1),
                      bn, bd);
            // hold the sender until the block has emptied
            if (i == count / 2) begin
                s_tvalid <= 0;
                while (sb.pending.size() != 0) @(posedge aclk);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: every op, extremes, zero denominators, unused op
        send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_item(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_item(OP_DIV, 32'd3, 32'd4, 32'hFFFF_FFFE, 32'd6);
        send_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd6);
        send_item(OP_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(OP_DEC, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_item(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
        send_item(OP_CMP, 32'd1, 32'hFFFF_FFFE, 32'd1, 32'd3);
        send_item(OP_CMP, 32'd5, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_CMP, 32'd1, 32'd2, 32'd1, 32'd0);
        send_item(OP_RED, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd0);
        send_item(OP_RED, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_item(OP_RED, 32'd5, 32'd0, 32'd0, 32'd0);
        send_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_item(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(4'd9, 32'd1, 32'd0, 32'd1, 32'd0);
        send_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        random_phase(500);
        send_idle_pct = 61;
        recv_idle_pct = 35;
        random_phase(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(500);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/rna_pkg.sv
rtl/rna_ctrl.sv
rtl/rna_dp.sv
rtl/rational_number_alu_core.sv
rtl/rna_checker.sv
test/rational_number_alu_core_tb.sv
